FILE: hw/rtl/oes_pkg.sv
// ----------------------------------------------------------------------------
// oes_pkg: shared types and constants for the odd-even transposition sorter.
// Field widths, the queue entry between front and back, the result entry and engine states.
// ----------------------------------------------------------------------------
package oes_pkg;

  localparam int unsigned ValueW = 32;
  localparam int unsigned TallyW = 12;
  localparam logic [TallyW-1:0] TallyMax = {TallyW{1'b1}};

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } in_req_t;

  typedef struct packed {
    logic [ValueW-1:0] sorted_value;
    logic              last_out;
    logic [TallyW-1:0] swap_count;
    logic [TallyW-1:0] compare_count;
    logic              overflow;
  } out_req_t;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkCmp,
    BkPhaseEnd,
    BkEmit
  } bk_state_e;

endpackage

FILE: hw/rtl/oes_if.sv
// ----------------------------------------------------------------------------
// oes_in_if / oes_out_if: valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface oes_in_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       value;
  logic                     last_in;
  modport source (output valid, value, last_in, input ready);
  modport sink   (input valid, value, last_in, output ready);
endinterface

interface oes_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [31:0]       sorted_value;
  logic                     last_out;
  logic [11:0]              swap_count;
  logic [11:0]              compare_count;
  logic                     overflow;
  modport source (output valid, sorted_value, last_out, swap_count, compare_count,
                  overflow, input ready);
  modport sink   (input valid, sorted_value, last_out, swap_count, compare_count,
                  overflow, output ready);
endinterface

FILE: hw/rtl/oes_queue.sv
// ----------------------------------------------------------------------------
// oes_queue: two-entry request queue between front end and sort engine.
// ----------------------------------------------------------------------------
module oes_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  oes_pkg::in_req_t  push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output oes_pkg::in_req_t  pop_data_o
);
  oes_pkg::in_req_t mem_q [2];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i && !full_o) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i && !empty_o) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'((push_i && !full_o) ? 1 : 0) - 2'((pop_i && !empty_o) ? 1 : 0);
    end
  end
endmodule

FILE: hw/rtl/oes_engine.sv
// ----------------------------------------------------------------------------
// oes_engine: back end. Stores elements, runs odd-even passes over the
// element memory one pair at a time, then streams the sorted set out.
// ----------------------------------------------------------------------------
module oes_engine #(
  parameter int unsigned MaxElements = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  oes_pkg::in_req_t  req_i,
  output logic              req_pop_o,
  output logic              res_valid_o,
  output oes_pkg::out_req_t res_o,
  input  logic              res_ready_i,
  output logic              busy_o
);
  localparam int unsigned IdxW = $clog2(MaxElements);
  localparam int unsigned CntW = $clog2(MaxElements + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxElements);

  logic [oes_pkg::ValueW-1:0] mem_q [MaxElements];

  oes_pkg::bk_state_e state_q, state_d;
  logic [CntW-1:0] count_q;
  logic            ovf_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            odd_q, odd_d;
  logic            swapped_q, swapped_d;
  logic [oes_pkg::TallyW-1:0] swaps_q, swaps_d, cmps_q, cmps_d;
  logic [oes_pkg::ValueW-1:0] a_q, b_q;
  logic [CntW-1:0] emit_q, emit_d;
  logic            res_valid_q;
  logic            swap;
  logic            has_pair;
  logic            load;

  // pair at idx exists when idx+1 < count
  assign has_pair = ({1'b0, idx_q} + (CntW+1)'(1)) < {1'b0, count_q};
  assign swap     = $signed(a_q) > $signed(b_q);
  assign load     = (state_q == oes_pkg::BkIdle) && req_valid_i;
  assign req_pop_o = load;
  assign busy_o   = (state_q != oes_pkg::BkIdle);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    odd_d     = odd_q;
    swapped_d = swapped_q;
    swaps_d   = swaps_q;
    cmps_d    = cmps_q;
    emit_d    = emit_q;
    unique case (state_q)
      oes_pkg::BkIdle: begin
        if (load && req_i.last) begin
          state_d = oes_pkg::BkRead;
          idx_d = '0; odd_d = 1'b0; swapped_d = 1'b0;
          swaps_d = '0; cmps_d = '0;
        end
      end
      oes_pkg::BkRead: begin
        if (has_pair) state_d = oes_pkg::BkCmp;
        else state_d = oes_pkg::BkPhaseEnd;
      end
      oes_pkg::BkCmp: begin
        if (cmps_q != oes_pkg::TallyMax) cmps_d = cmps_q + 1'b1;
        if (swap) begin
          swapped_d = 1'b1;
          if (swaps_q != oes_pkg::TallyMax) swaps_d = swaps_q + 1'b1;
        end
        idx_d = idx_q + IdxW'(2);
        state_d = oes_pkg::BkRead;
        if (({1'b0, idx_q} + (CntW+1)'(3)) >= {1'b0, count_q})
          state_d = oes_pkg::BkPhaseEnd;
      end
      oes_pkg::BkPhaseEnd: begin
        if (!odd_q) begin
          odd_d = 1'b1; idx_d = IdxW'(1); state_d = oes_pkg::BkRead;
        end else if (swapped_q) begin
          odd_d = 1'b0; idx_d = '0; swapped_d = 1'b0; state_d = oes_pkg::BkRead;
        end else begin
          emit_d = '0; idx_d = '0; state_d = oes_pkg::BkEmit;
        end
      end
      oes_pkg::BkEmit: begin
        if (!res_valid_q || res_ready_i) begin
          emit_d = emit_q + 1'b1;
          idx_d  = idx_q + 1'b1;
          if (emit_q + 1'b1 == count_q) state_d = oes_pkg::BkIdle;
        end
      end
      default: state_d = oes_pkg::BkIdle;
    endcase
  end

  // memory: load and swap writes, registered pair read
  always_ff @(posedge clk_i) begin
    if (load && count_q < CntMax) mem_q[count_q[IdxW-1:0]] <= req_i.value;
    else if (state_q == oes_pkg::BkCmp && swap) begin
      mem_q[idx_q] <= b_q;
    end
    if (state_q == oes_pkg::BkRead) begin
      a_q <= mem_q[idx_q];
      b_q <= mem_q[idx_q + IdxW'(1)];
    end
    if (state_q == oes_pkg::BkCmp && swap) mem_q[idx_q + IdxW'(1)] <= a_q;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == oes_pkg::BkEmit && (!res_valid_q || res_ready_i)) begin
      res_o.sorted_value  <= mem_q[idx_q];
      res_o.last_out      <= (emit_q + 1'b1 == count_q);
      res_o.swap_count    <= swaps_q;
      res_o.compare_count <= cmps_q;
      res_o.overflow      <= ovf_q;
    end
  end
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= oes_pkg::BkIdle;
      count_q <= '0; ovf_q <= 1'b0;
      idx_q <= '0; odd_q <= 1'b0; swapped_q <= 1'b0;
      swaps_q <= '0; cmps_q <= '0; emit_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d; odd_q <= odd_d; swapped_q <= swapped_d;
      swaps_q <= swaps_d; cmps_q <= cmps_d; emit_q <= emit_d;
      if (load) begin
        if (count_q < CntMax) count_q <= count_q + 1'b1;
        else ovf_q <= 1'b1;
      end
      if (state_q == oes_pkg::BkEmit && (!res_valid_q || res_ready_i)) begin
        res_valid_q <= 1'b1;
        if (emit_q + 1'b1 == count_q) begin
          count_q <= '0; ovf_q <= 1'b0;
        end
      end else if (res_ready_i) res_valid_q <= 1'b0;
    end
  end
endmodule

FILE: hw/rtl/odd_even_sort_with_counts.sv
// Sequence: after the last request of a set is accepted, the engine runs
//   passes of an even and an odd phase of pair reads and compares until a
//   pass makes no swap, then emits the sorted set.
// Throughput: one request per cycle while the engine loads, then one result
//   per cycle while out_o.ready holds; each pair is read, then compared.
// Reset (rst_ni low, async): counts, tallies, flags and handshakes clear;
//   element storage holds garbage until written.
// ----------------------------------------------------------------------------
// odd_even_sort_with_counts: odd-even transposition sorter with tallies.
// Front end queues incoming requests; the engine loads, sorts and emits.
// ----------------------------------------------------------------------------
module odd_even_sort_with_counts #(
  parameter int unsigned MAX_ELEMENTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  oes_in_if.sink    in_i,
  oes_out_if.source out_o
);
  oes_pkg::in_req_t  push_data, pop_data;
  oes_pkg::out_req_t res;
  logic q_full, q_empty, q_pop, busy;

  // front: accept whenever the queue has room
  assign in_i.ready       = !q_full;
  assign push_data.value  = in_i.value;
  assign push_data.last   = in_i.last_in;

  oes_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (in_i.valid),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_data)
  );

  // back: load, sort and emit
  oes_engine #(.MaxElements(MAX_ELEMENTS)) u_engine (
    .clk_i, .rst_ni,
    .req_valid_i (!q_empty),
    .req_i       (pop_data),
    .req_pop_o   (q_pop),
    .res_valid_o (out_o.valid),
    .res_o       (res),
    .res_ready_i (out_o.ready),
    .busy_o      (busy)
  );

  assign out_o.sorted_value  = res.sorted_value;
  assign out_o.last_out      = res.last_out;
  assign out_o.swap_count    = res.swap_count;
  assign out_o.compare_count = res.compare_count;
  assign out_o.overflow      = res.overflow;

  // the engine never pops the queue while busy sorting
  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !q_pop) else $error("queue popped while engine busy");
  // swaps never exceed comparisons
  a_swaps_le_cmps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.swap_count <= out_o.compare_count)
    else $error("swap tally exceeds compare tally");
  // a refused request only when the queue is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> q_full) else $error("ready low with room in queue");
endmodule
